@@ design/mlfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants
// Entry layout, result layout, operation and register codes and the sequencer
// states of the scheduler task table.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int IDX_W     = 6;
    localparam int LVL_W     = 2;
    localparam int CNT_W     = 16;
    localparam int PROM_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [PROM_W-1:0] PROM_MAX = {PROM_W{1'b1}};

    localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
    localparam logic [LVL_W-1:0] LVL_ONE = 2'd1;
    localparam logic [LVL_W-1:0] LVL_TWO = 2'd2;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_L1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_L2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_L3 = 2'd2;

    localparam logic [CNT_W-1:0] AGE_LIMIT_RESET = 16'd30;

    typedef struct packed {
        logic [CNT_W-1:0] slice;
        logic [CNT_W-1:0] waiting;
        logic [LVL_W-1:0] level;
        logic             runnable;
    } entry_t;

    typedef struct packed {
        logic [PROM_W-1:0] promoted;
        entry_t            entry;
    } result_t;

    typedef struct packed {
        entry_t entry;
        logic   write;
        logic   promote;
    } age_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RDWAIT,
        S_WALK,
        S_DONE
    } state_t;

endpackage

@@ design/mlfq_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_table: task entry memory
// One write port and one registered read port. A valid bit per entry is
// cleared by reset, and an entry that was never written reads as zero.
// ----------------------------------------------------------------------------
module mlfq_table
    import mlfq_pkg::*;
#(
    parameter int NUM_ENTRIES = 64,
    parameter int AW          = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t                 mem_reg [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    entry_t                 rd_q_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

@@ design/mlfq_age_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_age_unit: aging update for one entry
// Bumps the waiting count of a runnable, non-running entry and decides
// whether it moves up one queue level.
// ----------------------------------------------------------------------------
module mlfq_age_unit
    import mlfq_pkg::*;
(
    input  entry_t           cur,
    input  logic             running,
    input  logic [CNT_W-1:0] limit_l1,
    input  logic [CNT_W-1:0] limit_l2,
    input  logic [CNT_W-1:0] limit_l3,
    output age_out_t         res
);

    logic             active;
    logic [CNT_W-1:0] waited;
    logic [CNT_W-1:0] limit;

    always_comb begin
        active = cur.runnable && !running;
        waited = (cur.waiting == CNT_MAX) ? cur.waiting : cur.waiting + 1'b1;
        case (cur.level)
            LVL_ONE: limit = limit_l1;
            LVL_TWO: limit = limit_l2;
            default: limit = limit_l3;
        endcase

        res.write         = active;
        res.promote       = active && (cur.level != LVL_TOP) && (waited >= limit);
        res.entry         = cur;
        res.entry.waiting = waited;
        if (res.promote) begin
            res.entry.level   = cur.level - 1'b1;
            res.entry.waiting = '0;
            res.entry.slice   = '0;
        end
    end

endmodule

@@ design/mlfq_priority_aging.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_priority_aging: scheduler task table with priority aging
// Holds task entries for a multi-level feedback queue and ages waiting
// entries on every timer tick, one entry per cycle through a shared unit.
// ----------------------------------------------------------------------------
//  Channel | Ports          | Carries
//  --------+----------------+---------------------------------------------
//  input   | s_t*           | one request: tick, entry write or entry read
//  result  | m_t*           | one result per request, entry and promotions
//  config  | cfg_*          | aging limits, index 0..2, write only
//
//  A request is taken only while the sequencer is idle. A write passes through
//  the start and done states, a read through start, read wait and done; a tick
//  walks the table, the single read port feeding the age unit one entry per cycle.
//  Reset clears the per-entry valid bits at once; there is no clearing pass.
//  A result that is not taken holds the sequencer until the result register frees.
// ----------------------------------------------------------------------------
module mlfq_priority_aging
    import mlfq_pkg::*;
#(
    parameter int NUM_ENTRIES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, from bit 0: entry_index[6], set_runnable[1], set_level[2],
    // set_waiting[16], set_slice[16], zero fill
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    // s_tuser: opcode[2]
    input  logic [1:0]           s_tuser,
    // m_tdata, from bit 0: entry_runnable[1], entry_level[2], entry_waiting[16],
    // entry_slice[16], promoted_count[7], zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CNT_W-1:0]     cfg_wdata
);

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [AW:0] LAST = (AW+1)'(NUM_ENTRIES);

    state_t             state_reg,  state_next;
    logic [1:0]         op_reg,     op_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    entry_t             set_reg,    set_next;
    logic [AW:0]        rd_ptr_reg, rd_ptr_next;
    logic               pend_reg,   pend_next;
    logic [AW-1:0]      proc_reg,   proc_next;
    result_t            res_reg,    res_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_data_reg,  m_data_next;

    logic [CNT_W-1:0]   lim1_reg, lim2_reg, lim3_reg;

    logic               tbl_wr_en;
    logic [AW-1:0]      tbl_wr_addr;
    entry_t             tbl_wr_data;
    logic               tbl_rd_en;
    logic [AW-1:0]      tbl_rd_addr;
    entry_t             tbl_rd_data;

    logic               idx_valid;
    logic [AW-1:0]      idx_addr;
    logic               running;
    logic               issue;
    age_out_t           age;

    assign idx_valid = 32'(idx_reg) < NUM_ENTRIES;
    assign idx_addr  = AW'(idx_reg);
    assign running   = idx_valid && (proc_reg == idx_addr);
    assign issue     = (rd_ptr_reg != LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim1_reg <= AGE_LIMIT_RESET;
            lim2_reg <= AGE_LIMIT_RESET;
            lim3_reg <= AGE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_AGE_L1: lim1_reg <= cfg_wdata;
                CFG_AGE_L2: lim2_reg <= cfg_wdata;
                CFG_AGE_L3: lim3_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mlfq_table #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .AW          (AW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    mlfq_age_unit u_age (
        .cur      (tbl_rd_data),
        .running  (running),
        .limit_l1 (lim1_reg),
        .limit_l2 (lim2_reg),
        .limit_l3 (lim3_reg),
        .res      (age)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        set_reg    <= set_next;
        rd_ptr_reg <= rd_ptr_next;
        proc_reg   <= proc_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        set_next     = set_reg;
        rd_ptr_next  = rd_ptr_reg;
        pend_next    = pend_reg;
        proc_next    = proc_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = proc_reg;
        tbl_wr_data  = age.entry;
        tbl_rd_en    = 1'b0;
        tbl_rd_addr  = rd_ptr_reg[AW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next          = s_tuser;
                    idx_next         = s_tdata[5:0];
                    set_next.runnable = s_tdata[6];
                    set_next.level   = s_tdata[8:7];
                    set_next.waiting = s_tdata[24:9];
                    set_next.slice   = s_tdata[40:25];
                    state_next       = S_START;
                end
            end
            S_START: begin
                res_next = '0;
                case (op_reg)
                    OP_TICK: begin
                        rd_ptr_next = '0;
                        pend_next   = 1'b0;
                        state_next  = S_WALK;
                    end
                    OP_WRITE: begin
                        if (idx_valid) begin
                            tbl_wr_en      = 1'b1;
                            tbl_wr_addr    = idx_addr;
                            tbl_wr_data    = set_reg;
                            res_next.entry = set_reg;
                        end
                        state_next = S_DONE;
                    end
                    OP_READ: begin
                        tbl_rd_en   = idx_valid;
                        tbl_rd_addr = idx_addr;
                        state_next  = S_RDWAIT;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDWAIT: begin
                if (idx_valid) begin
                    res_next.entry = tbl_rd_data;
                end
                state_next = S_DONE;
            end
            S_WALK: begin
                // Read entry i while entry i-1 is updated and written back.
                if (issue) begin
                    tbl_rd_en   = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    proc_next   = rd_ptr_reg[AW-1:0];
                end
                pend_next = issue;
                if (pend_reg) begin
                    tbl_wr_en = age.write;
                    if (age.promote && (res_reg.promoted != PROM_MAX)) begin
                        res_next.promoted = res_reg.promoted + 1'b1;
                    end
                    // The running entry is left alone, so its stored value is the result.
                    if (running) begin
                        res_next.entry = tbl_rd_data;
                    end
                end
                if (!issue && !pend_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg.promoted, m_data_reg.entry.slice,
                       m_data_reg.entry.waiting, m_data_reg.entry.level,
                       m_data_reg.entry.runnable};

    a_write_only_in_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr_en |-> ((state_reg == S_START && op_reg == OP_WRITE) || state_reg == S_WALK))
        else $error("table written outside a write request or a tick walk");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished request");

    a_promoted_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && op_reg != OP_TICK) |-> (res_reg.promoted == '0))
        else $error("promotion count nonzero for a request other than a tick");

    a_walk_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (rd_ptr_reg <= LAST))
        else $error("tick walk ran past the end of the table");

    a_done_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && !issue && !pend_reg) |=> (state_reg == S_DONE))
        else $error("tick walk did not finish after the last entry");

endmodule
